[hdl/lkct_pkg.sv]
// Shared types and constants of the LRU key cache tracker.
package lkct_pkg;

    localparam int CLASS_W    = 64;
    localparam int OP_W       = 2;
    localparam int KEY_W      = CLASS_W + OP_W;
    localparam int CAP_W      = 5;
    localparam int OCC_W      = 5;
    localparam int IN_TDATA_W = 72;
    localparam int RES_W      = 2 + KEY_W + OCC_W;
    localparam int OUT_TDATA_W = 80;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    // Key as it sits in tdata: class identifier low, operation above it.
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [CLASS_W-1:0] class_id;
    } key_t;

    // Result as it sits in m_tdata, lowest field last.
    typedef struct packed {
        logic [OCC_W-1:0] occupancy;
        key_t             evicted_key;
        logic             evicted;
        logic             hit;
    } result_t;

    // Per-cycle commands broadcast to every cell.
    typedef struct packed {
        logic cmp_en;
        logic upd_en;
    } ctl_t;

endpackage

[hdl/lkct_cell.sv]
// One recency slot: holds a key, compares it, and shifts from its neighbor.
module lkct_cell #(
    parameter int NW  = 5,
    parameter int IDX = 0
) (
    input  logic              clk,
    input  lkct_pkg::ctl_t    ctl,
    input  lkct_pkg::key_t    cmp_key,
    input  logic [NW-1:0]     count,
    input  logic [NW-1:0]     last_idx,
    input  lkct_pkg::key_t    prev_key,
    input  logic              hit_in,
    output logic              hit_out,
    input  lkct_pkg::key_t    evict_in,
    output lkct_pkg::key_t    evict_out,
    output lkct_pkg::key_t    key_q
);
    import lkct_pkg::*;

    localparam logic [NW-1:0] IDX_N = NW'(IDX);

    key_t key_reg;
    key_t key_next;
    logic match_reg;

    // Slots up to and including the hit slot take their neighbor's key; on a
    // miss no slot has seen a hit, so the whole row moves down by one.
    assign key_next  = hit_in ? key_reg : prev_key;
    assign hit_out   = hit_in | match_reg;
    assign evict_out = evict_in | ((IDX_N == last_idx) ? key_next : key_t'('0));
    assign key_q     = key_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.cmp_en)
        begin
            match_reg <= (IDX_N < count) && (key_reg == cmp_key);
        end
        if (ctl.upd_en)
        begin
            key_reg <= key_next;
        end
    end

endmodule

[hdl/lru_key_cache_tracker_unit.sv]
// Top level of the fully associative LRU key cache tracker.
//
// Usage: each beat on the slave stream (s_tvalid/s_tready) carries one key,
// a 64-bit class identifier and a 2-bit operation, in s_tdata, and the command
// in s_tuser (lookup or clear). Every beat yields exactly one result beat on
// the master stream (m_tvalid/m_tready) with the hit flag, the eviction flag,
// the evicted key and the occupancy after the beat.
// The keys live in a row of DEPTH cells ordered from most recent (cell 0) to
// least recent. In the cycle a beat is accepted, every cell compares its key
// with the incoming one. In the following cycle, for a lookup, a hit prefix
// ripples along the row, the cells up to the hit slot (all cells on a miss)
// shift by one and the new key enters cell 0. For either command the result is
// then loaded into the output register, and m_tvalid rises once it is held there.
// A new beat is not taken while the last one is in its update step, since the
// compare and the shift of the cell row happen in turn. The output register
// holds a result until it is taken, and a new beat is taken no earlier than
// the cycle in which the waiting result leaves.
// Reset empties the store (occupancy zero), sets capacity to 16, and leaves the key
// cells as they are. The user writes the capacity via cfg_we/cfg_wdata only while
// idle (not enforced); a lowered capacity drops all excess keys on the next lookup.
module lru_key_cache_tracker_unit #(
    parameter int DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [63:0] class_id, [65:64] op_kind, [71:66] zero
    input  logic [lkct_pkg::IN_TDATA_W-1:0]     s_tdata,
    // [0] command
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] hit, [1] evicted, [65:2] evicted_class_id, [67:66] evicted_op,
    // [72:68] occupancy, [79:73] zero
    output logic [lkct_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                                cfg_we,
    input  logic [lkct_pkg::CAP_W-1:0]          cfg_wdata
);
    import lkct_pkg::*;

    // Counter width: holds DEPTH + 1 and is never narrower than the capacity.
    localparam int CW = $clog2(DEPTH + 2);
    localparam int NW = (CW > CAP_W) ? CW : CAP_W;
    localparam logic [NW-1:0] DEPTH_N = NW'(DEPTH);
    localparam logic [NW-1:0] ONE_N   = NW'(1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_UPD  = 1'b1;

    logic             state_reg, state_next;
    logic [NW-1:0]    count_reg, count_next;
    logic [CAP_W-1:0] cap_reg;
    key_t             pend_key_reg;
    logic             cmd_reg;
    logic             out_valid_reg, out_valid_next;
    result_t          out_data_reg, out_data_next;

    ctl_t             ctl;
    logic             s_accept;
    key_t             in_key;
    logic [NW-1:0]    n_keys;
    logic [NW-1:0]    last_idx;
    logic [NW-1:0]    cap_eff;
    logic             drop;
    logic             hit;
    key_t             evict_key;

    key_t             key_q  [DEPTH];
    logic             hit_ch [DEPTH+1];
    key_t             ev_ch  [DEPTH+1];

    assign in_key   = key_t'(s_tdata[KEY_W-1:0]);
    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign s_accept = s_tvalid && s_tready;

    assign ctl.cmp_en = s_accept;
    assign ctl.upd_en = (state_reg == ST_UPD) && (cmd_reg == CMD_LOOKUP);

    assign hit_ch[0] = 1'b0;
    assign ev_ch[0]  = key_t'('0);

    // The row of cells: cell 0 takes the pending key, every other cell takes
    // the key of the cell before it.
    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        key_t prev;
        if (k == 0)
        begin : g_head
            assign prev = pend_key_reg;
        end
        else
        begin : g_body
            assign prev = key_q[k-1];
        end
        lkct_cell #(
            .NW  (NW),
            .IDX (k)
        ) u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .cmp_key   (in_key),
            .count     (count_reg),
            .last_idx  (last_idx),
            .prev_key  (prev),
            .hit_in    (hit_ch[k]),
            .hit_out   (hit_ch[k+1]),
            .evict_in  (ev_ch[k]),
            .evict_out (ev_ch[k+1]),
            .key_q     (key_q[k])
        );
    end

    // Keys are unique in the store, so at most one cell reports a match.
    assign hit = hit_ch[DEPTH];

    // After the shift the least recent key sits at slot n_keys - 1. When all DEPTH
    // cells held keys and the lookup missed, that key is the one pushed out of the last cell.
    assign n_keys   = hit ? count_reg : (count_reg + ONE_N);
    assign last_idx = n_keys - ONE_N;

    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = ONE_N;
        end
        else if (NW'(cap_reg) > DEPTH_N)
        begin
            cap_eff = DEPTH_N;
        end
        else
        begin
            cap_eff = NW'(cap_reg);
        end
    end

    assign drop      = n_keys > cap_eff;
    assign evict_key = (last_idx == DEPTH_N) ? key_q[DEPTH-1] : ev_ch[DEPTH];

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                state_next     = ST_IDLE;
                out_valid_next = 1'b1;
                if (cmd_reg == CMD_CLEAR)
                begin
                    count_next    = '0;
                    out_data_next = result_t'('0);
                end
                else
                begin
                    count_next                = drop ? cap_eff : n_keys;
                    out_data_next.hit         = hit;
                    out_data_next.evicted     = drop;
                    out_data_next.evicted_key = drop ? evict_key : key_t'('0);
                    out_data_next.occupancy   = count_next[OCC_W-1:0];
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cap_reg       <= CAPACITY_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (s_accept)
        begin
            pend_key_reg <= in_key;
            cmd_reg      <= s_tuser;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - RES_W){1'b0}}, out_data_reg};

endmodule

[hdl/lkct_checker.sv]
// Port-level checks for the LRU key cache tracker, bound to the top level.
module lkct_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata
);

    // Every accepted beat shows its result after its update step.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |-> ##2 m_tvalid)
        else $error("result beat missing two cycles after acceptance");

    // The block never takes a beat while the update of the last one is in progress.
    a_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("beat accepted in the cycle after another");

    // A clear beat empties the store and reports no hit.
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser) |-> ##2
        (m_tdata[72:68] == 5'd0 && m_tdata[0] == 1'b0 && m_tdata[1] == 1'b0))
        else $error("clear beat left entries or flags");

    // Without an eviction the evicted key reads as zero.
    a_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[1]) |-> (m_tdata[67:2] == 66'd0))
        else $error("evicted key nonzero without eviction");

    // A stalled result stays put.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind lru_key_cache_tracker_unit lkct_checker u_lkct_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
